/* hdl/bcs_pkg.sv */
// Shared constants, types and helpers of the Bezier curve sampler.
package bcs_pkg;

	localparam int MaxPoints   = 16;
	localparam int MaxSegments = 1024;
	localparam int CoordW      = 32;
	localparam int LenW        = 48;
	localparam int SegW        = 11;
	localparam int PtsW        = 5;
	localparam int SlotW       = $clog2(MaxPoints);
	localparam int TW          = 17;
	localparam int NumW        = SegW + 16;
	localparam int DivSteps    = NumW;
	localparam int ProdW       = CoordW + TW;
	localparam int SqW         = 2 * CoordW;
	localparam int RadW        = SqW + 2;
	localparam int RootW       = RadW / 2;
	localparam int SqRemW      = RootW + 4;
	localparam int SqrtSteps   = RootW;
	localparam int CntW        = 6;
	localparam int LenSumW     = LenW + 1;

	localparam logic [CoordW-1:0] SignBias = 32'h8000_0000;
	localparam logic [TW-1:0]     OneQ16   = 17'h1_0000;
	localparam logic [ProdW:0]    HalfLsb  = 50'd32768;

	localparam logic [SegW-1:0] SegReset = 11'd100;
	localparam logic [PtsW-1:0] PtsReset = 5'd2;

	localparam logic RegSegCount   = 1'b0;
	localparam logic RegPointCount = 1'b1;

	localparam logic FuncWrite = 1'b0;
	localparam logic FuncEval  = 1'b1;

	typedef struct packed {
		logic             wr_point;
		logic             start;
		logic             div_step;
		logic             rd_en;
		logic             rd_ctrl;
		logic [SlotW-1:0] addr;
		logic             mul_en;
		logic             wr_scr;
		logic             sq_en;
		logic             sqrt_init;
		logic             sqrt_step;
		logic             finish;
	} cmd_t;

	typedef struct packed {
		logic i_zero;
	} sts_t;

	function automatic logic [SegW-1:0] clamp_seg(input logic [SegW-1:0] v);
		logic [SegW-1:0] r;
		r = v;
		if (v == '0) r = SegW'(1);
		else if (v > SegW'(MaxSegments)) r = SegW'(MaxSegments);
		return r;
	endfunction

	function automatic logic [PtsW-1:0] clamp_pts(input logic [PtsW-1:0] v);
		logic [PtsW-1:0] r;
		r = v;
		if (v < PtsW'(2)) r = PtsW'(2);
		else if (v > PtsW'(MaxPoints)) r = PtsW'(MaxPoints);
		return r;
	endfunction

endpackage

/* hdl/bcs_ctrl.sv */
// Controller state machine sequencing division, interpolation and square root.
module bcs_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      func,
	output logic                      out_valid,
	input  logic                      out_ready,
	input  logic [bcs_pkg::PtsW-1:0]  pts_cfg,
	input  bcs_pkg::sts_t             sts,
	output bcs_pkg::cmd_t             cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_RD, ST_MUL, ST_WR, ST_SQ, ST_SQI, ST_SQRT, ST_FIN
	} state_t;

	state_t                       state_q;
	logic [bcs_pkg::CntW-1:0]     cnt_q;
	logic [bcs_pkg::SlotW-1:0]    lvl_q;
	logic [bcs_pkg::SlotW-1:0]    k_q;
	logic [bcs_pkg::PtsW-1:0]     pts_q;
	logic                         out_valid_q;
	logic [bcs_pkg::PtsW-1:0]     last_k;
	logic [bcs_pkg::PtsW-1:0]     last_lvl;
	logic                         fin_go;

	assign last_k   = pts_q - bcs_pkg::PtsW'(2) - {1'b0, lvl_q};
	assign last_lvl = pts_q - bcs_pkg::PtsW'(2);
	assign fin_go   = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.addr      = k_q;
		cmd.wr_point  = (state_q == ST_IDLE) && in_valid && (func == bcs_pkg::FuncWrite);
		cmd.start     = (state_q == ST_IDLE) && in_valid && (func == bcs_pkg::FuncEval);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.rd_en     = (state_q == ST_RD);
		cmd.rd_ctrl   = (lvl_q == '0);
		cmd.mul_en    = (state_q == ST_MUL);
		cmd.wr_scr    = (state_q == ST_WR);
		cmd.sq_en     = (state_q == ST_SQ);
		cmd.sqrt_init = (state_q == ST_SQI);
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.finish    = fin_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			lvl_q       <= '0;
			k_q         <= '0;
			pts_q       <= bcs_pkg::PtsReset;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && (func == bcs_pkg::FuncEval)) begin
						pts_q   <= bcs_pkg::clamp_pts(pts_cfg);
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + bcs_pkg::CntW'(1);
					if (cnt_q == bcs_pkg::CntW'(bcs_pkg::DivSteps - 1)) begin
						lvl_q   <= '0;
						k_q     <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD:  state_q <= ST_MUL;
				ST_MUL: state_q <= ST_WR;
				ST_WR: begin
					if ({1'b0, k_q} == last_k) begin
						if ({1'b0, lvl_q} == last_lvl) begin
							state_q <= sts.i_zero ? ST_FIN : ST_SQ;
						end else begin
							lvl_q   <= lvl_q + bcs_pkg::SlotW'(1);
							k_q     <= '0;
							state_q <= ST_RD;
						end
					end else begin
						k_q     <= k_q + bcs_pkg::SlotW'(1);
						state_q <= ST_RD;
					end
				end
				ST_SQ:  state_q <= ST_SQI;
				ST_SQI: begin
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + bcs_pkg::CntW'(1);
					if (cnt_q == bcs_pkg::CntW'(bcs_pkg::SqrtSteps - 1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hdl/bcs_dpath.sv */
// Datapath: control point store, t divider, interpolation unit, square root, length.
module bcs_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bcs_pkg::cmd_t                cmd,
	output bcs_pkg::sts_t                sts,
	input  logic [bcs_pkg::SlotW-1:0]    point_index,
	input  logic signed [bcs_pkg::CoordW-1:0] point_x,
	input  logic signed [bcs_pkg::CoordW-1:0] point_y,
	input  logic [bcs_pkg::SegW-1:0]     sample_index,
	input  logic [bcs_pkg::SegW-1:0]     seg_cfg,
	output logic signed [bcs_pkg::CoordW-1:0] curve_x,
	output logic signed [bcs_pkg::CoordW-1:0] curve_y,
	output logic [bcs_pkg::LenW-1:0]     path_length
);

	localparam int CW = bcs_pkg::CoordW;

	logic [CW-1:0] ctrl_x_mem [bcs_pkg::MaxPoints];
	logic [CW-1:0] ctrl_y_mem [bcs_pkg::MaxPoints];
	logic [CW-1:0] scr_x_mem  [bcs_pkg::MaxPoints-1];
	logic [CW-1:0] scr_y_mem  [bcs_pkg::MaxPoints-1];

	logic [bcs_pkg::SegW-1:0]  seg_q;
	logic                      i_zero_q;
	logic [bcs_pkg::NumW-1:0]  num_q;
	logic [bcs_pkg::SegW-1:0]  rem_q;
	logic [bcs_pkg::TW-1:0]    t_q;

	logic [CW-1:0] a_x_q, b_x_q, a_y_q, b_y_q;
	logic [bcs_pkg::ProdW-1:0] p_ax_q, p_bx_q, p_ay_q, p_by_q;
	logic [CW-1:0] cur_x_q, cur_y_q;
	logic [CW-1:0] prev_x_q, prev_y_q;
	logic [bcs_pkg::SqW-1:0] sq_x_q, sq_y_q;
	logic [bcs_pkg::RadW-1:0] rad_q;
	logic [bcs_pkg::SqRemW-1:0] sqrem_q;
	logic [bcs_pkg::RootW-1:0] root_q;
	logic [bcs_pkg::LenW-1:0] acc_q;
	logic [CW-1:0] out_x_q, out_y_q;
	logic [bcs_pkg::LenW-1:0] out_len_q;

	logic [bcs_pkg::SegW-1:0] seg_e, i_e;
	logic [bcs_pkg::SegW:0]   r2;
	logic [bcs_pkg::TW-1:0]   t_c;
	logic [bcs_pkg::ProdW:0]  sum_x, sum_y;
	logic [CW-1:0]            res_x, res_y, dx, dy;
	logic [bcs_pkg::SqRemW-1:0] rem_n, trial;
	logic [bcs_pkg::LenSumW-1:0] acc_sum;
	logic [bcs_pkg::SlotW-1:0] addr_n;

	assign seg_e  = bcs_pkg::clamp_seg(seg_cfg);
	assign i_e    = (sample_index > seg_e) ? seg_e : sample_index;
	assign r2     = {rem_q, num_q[bcs_pkg::NumW-1]};
	assign t_c    = bcs_pkg::OneQ16 - t_q;
	assign sum_x  = {1'b0, p_ax_q} + {1'b0, p_bx_q} + bcs_pkg::HalfLsb;
	assign sum_y  = {1'b0, p_ay_q} + {1'b0, p_by_q} + bcs_pkg::HalfLsb;
	assign res_x  = sum_x[CW+15:16];
	assign res_y  = sum_y[CW+15:16];
	assign dx     = (cur_x_q > prev_x_q) ? cur_x_q - prev_x_q : prev_x_q - cur_x_q;
	assign dy     = (cur_y_q > prev_y_q) ? cur_y_q - prev_y_q : prev_y_q - cur_y_q;
	assign rem_n  = {sqrem_q[bcs_pkg::SqRemW-3:0], rad_q[bcs_pkg::RadW-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign acc_sum = {1'b0, acc_q} + bcs_pkg::LenSumW'(root_q);
	assign addr_n = cmd.addr + bcs_pkg::SlotW'(1);

	assign sts.i_zero = i_zero_q;
	assign curve_x     = out_x_q;
	assign curve_y     = out_y_q;
	assign path_length = out_len_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_point) begin
			ctrl_x_mem[point_index] <= point_x ^ bcs_pkg::SignBias;
			ctrl_y_mem[point_index] <= point_y ^ bcs_pkg::SignBias;
		end
		if (cmd.wr_scr) begin
			scr_x_mem[cmd.addr] <= res_x;
			scr_y_mem[cmd.addr] <= res_y;
		end
		if (cmd.rd_en) begin
			if (cmd.rd_ctrl) begin
				a_x_q <= ctrl_x_mem[cmd.addr];
				b_x_q <= ctrl_x_mem[addr_n];
				a_y_q <= ctrl_y_mem[cmd.addr];
				b_y_q <= ctrl_y_mem[addr_n];
			end else begin
				a_x_q <= scr_x_mem[cmd.addr];
				b_x_q <= scr_x_mem[addr_n];
				a_y_q <= scr_y_mem[cmd.addr];
				b_y_q <= scr_y_mem[addr_n];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			seg_q    <= seg_e;
			i_zero_q <= (i_e == '0);
			num_q    <= {i_e, 16'h0} + bcs_pkg::NumW'(seg_e[bcs_pkg::SegW-1:1]);
			rem_q    <= '0;
			t_q      <= '0;
		end
		if (cmd.div_step) begin
			num_q <= {num_q[bcs_pkg::NumW-2:0], 1'b0};
			if (r2 >= {1'b0, seg_q}) begin
				rem_q <= bcs_pkg::SegW'(r2 - {1'b0, seg_q});
				t_q   <= {t_q[bcs_pkg::TW-2:0], 1'b1};
			end else begin
				rem_q <= r2[bcs_pkg::SegW-1:0];
				t_q   <= {t_q[bcs_pkg::TW-2:0], 1'b0};
			end
		end
		if (cmd.mul_en) begin
			p_ax_q <= {{bcs_pkg::TW{1'b0}}, a_x_q} * {{CW{1'b0}}, t_c};
			p_bx_q <= {{bcs_pkg::TW{1'b0}}, b_x_q} * {{CW{1'b0}}, t_q};
			p_ay_q <= {{bcs_pkg::TW{1'b0}}, a_y_q} * {{CW{1'b0}}, t_c};
			p_by_q <= {{bcs_pkg::TW{1'b0}}, b_y_q} * {{CW{1'b0}}, t_q};
		end
		if (cmd.wr_scr) begin
			cur_x_q <= res_x;
			cur_y_q <= res_y;
		end
		if (cmd.sq_en) begin
			sq_x_q <= {{CW{1'b0}}, dx} * {{CW{1'b0}}, dx};
			sq_y_q <= {{CW{1'b0}}, dy} * {{CW{1'b0}}, dy};
		end
		if (cmd.sqrt_init) begin
			rad_q   <= {1'b0, {1'b0, sq_x_q} + {1'b0, sq_y_q}};
			sqrem_q <= '0;
			root_q  <= '0;
		end
		if (cmd.sqrt_step) begin
			rad_q <= {rad_q[bcs_pkg::RadW-3:0], 2'b00};
			if (rem_n >= trial) begin
				sqrem_q <= rem_n - trial;
				root_q  <= {root_q[bcs_pkg::RootW-2:0], 1'b1};
			end else begin
				sqrem_q <= rem_n;
				root_q  <= {root_q[bcs_pkg::RootW-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			out_x_q <= cur_x_q ^ bcs_pkg::SignBias;
			out_y_q <= cur_y_q ^ bcs_pkg::SignBias;
			if (i_zero_q) out_len_q <= '0;
			else if (acc_sum[bcs_pkg::LenW]) out_len_q <= '1;
			else out_len_q <= acc_sum[bcs_pkg::LenW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= bcs_pkg::SignBias;
			prev_y_q <= bcs_pkg::SignBias;
			acc_q    <= '0;
		end else if (cmd.finish) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
			if (i_zero_q) acc_q <= '0;
			else if (acc_sum[bcs_pkg::LenW]) acc_q <= '1;
			else acc_q <= acc_sum[bcs_pkg::LenW-1:0];
		end
	end

endmodule

/* hdl/bezier_curve_sampler.sv */
// Top level of the Bezier curve sampler: APB registers, controller and datapath.
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per item. func 0 stores
//   point_x/point_y into slot point_index and gives no result. func 1
//   evaluates sample_index and gives one result on the output channel
//   (out_valid/out_ready): curve_x, curve_y and the running path_length.
//   Registers over APB: segment_count at 0x0, point_count at 0x4.
// Sequence:
//   An evaluation first divides for t (one quotient bit a cycle), then runs the
//   interpolations on the shared multiplier set (read, multiply, write each),
//   P*(P-1)/2 interpolations for P points, then the distance (square, load,
//   33 root bits); sample zero skips the square and the root.
//   One item is in flight at a time; in_ready is high while the block is idle.
// Reset: arst_n clears control state, segment_count to 100, point_count to 2,
//   the previous point and the length to zero. Control points are undefined
//   until written.
// Stall: a held result stays in the output register; the block keeps taking
//   items; a new evaluation then waits, in_ready low, until the old one is taken.
module bezier_curve_sampler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [3:0]  point_index,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic [10:0] sample_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] curve_x,
	output logic signed [31:0] curve_y,
	output logic [47:0] path_length,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [bcs_pkg::SegW-1:0] seg_q;
	logic [bcs_pkg::PtsW-1:0] pts_q;
	bcs_pkg::cmd_t            cmd;
	bcs_pkg::sts_t            sts;
	logic                     cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= bcs_pkg::SegReset;
			pts_q <= bcs_pkg::PtsReset;
		end else if (cfg_wr) begin
			if (paddr[2] == bcs_pkg::RegSegCount) seg_q <= pwdata[bcs_pkg::SegW-1:0];
			else pts_q <= pwdata[bcs_pkg::PtsW-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == bcs_pkg::RegSegCount) prdata = {21'h0, seg_q};
		else prdata = {27'h0, pts_q};
	end

	bcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pts_cfg   (pts_q),
		.sts       (sts),
		.cmd       (cmd)
	);

	bcs_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.point_index  (point_index),
		.point_x      (point_x),
		.point_y      (point_y),
		.sample_index (sample_index),
		.seg_cfg      (seg_q),
		.curve_x      (curve_x),
		.curve_y      (curve_y),
		.path_length  (path_length)
	);

`ifndef ASSERT_OFF
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (func == bcs_pkg::FuncWrite)) |=> !$rose(out_valid))
		else $error("point write produced a result");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (func == bcs_pkg::FuncEval)) |=> !in_ready)
		else $error("evaluation did not occupy the block");

	a_rise_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.finish))
		else $error("result raised without finishing an evaluation");
`endif

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the Bezier curve sampler: random and directed transactions.
`timescale 1ns / 1ps

module tb_top;

	typedef struct {
		logic        fn;
		logic [3:0]  slot;
		logic [31:0] px;
		logic [31:0] py;
		logic [10:0] si;
	} txn_t;

	typedef struct {
		logic [31:0] cx;
		logic [31:0] cy;
		logic [47:0] len;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready;
	logic func = 1'b0;
	logic [3:0] point_index = '0;
	logic signed [31:0] point_x = '0, point_y = '0;
	logic [10:0] sample_index = '0;
	logic out_valid, out_ready = 1'b0;
	logic signed [31:0] curve_x, curve_y;
	logic [47:0] path_length;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;

	bezier_curve_sampler DUT (.*);

	always #5 clk = ~clk;

	txn_t    pending[$];
	sample_t expected_samples[$];
	int      errors = 0;
	int      send_idle = 0, recv_idle = 0;
	logic    hold_off = 1'b0;
	int      phase = 0;

	// predictor state, coordinates held offset-binary
	logic [31:0] pt_x[bcs_pkg::MaxPoints], pt_y[bcs_pkg::MaxPoints];
	logic [31:0] last_x, last_y;
	logic [47:0] run_len;
	logic [10:0] seg_reg;
	logic [4:0]  pts_reg;

	function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b, logic [63:0] t);
		logic [63:0] s;
		s = 64'(a) * (64'd65536 - t) + 64'(b) * t;
		return 32'((s + 64'd32768) >> 16);
	endfunction

	function automatic logic [33:0] dist_root(logic [31:0] ax, logic [31:0] ay,
			logic [31:0] bx, logic [31:0] by);
		logic [65:0] dx, dy, sum;
		logic [33:0] r, c;
		dx = (ax > bx) ? 66'(ax - bx) : 66'(bx - ax);
		dy = (ay > by) ? 66'(ay - by) : 66'(by - ay);
		sum = dx * dx + dy * dy;
		r = '0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (34'd1 << b);
			if (68'(c) * 68'(c) <= 68'(sum)) r = c;
		end
		return r;
	endfunction

	function automatic sample_t eval_sample(logic [10:0] si_in);
		logic [63:0] seg, pts, i, t;
		logic [31:0] wx[bcs_pkg::MaxPoints], wy[bcs_pkg::MaxPoints];
		logic [48:0] acc;
		sample_t res;
		seg = seg_reg;
		if (seg < 1) seg = 1;
		if (seg > bcs_pkg::MaxSegments) seg = bcs_pkg::MaxSegments;
		pts = pts_reg;
		if (pts < 2) pts = 2;
		if (pts > bcs_pkg::MaxPoints) pts = bcs_pkg::MaxPoints;
		i = si_in;
		if (i > seg) i = seg;
		t = ((i << 16) + (seg >> 1)) / seg;
		for (int k = 0; k < bcs_pkg::MaxPoints; k++) begin
			wx[k] = pt_x[k];
			wy[k] = pt_y[k];
		end
		for (int lvl = int'(pts) - 1; lvl > 0; lvl--)
			for (int k = 0; k < lvl; k++) begin
				wx[k] = lerp(wx[k], wx[k+1], t);
				wy[k] = lerp(wy[k], wy[k+1], t);
			end
		if (i == 0) run_len = '0;
		else begin
			acc = 49'(run_len) + 49'(dist_root(wx[0], wy[0], last_x, last_y));
			run_len = acc[48] ? '1 : acc[47:0];
		end
		last_x = wx[0];
		last_y = wy[0];
		res.cx = wx[0] ^ bcs_pkg::SignBias;
		res.cy = wy[0] ^ bcs_pkg::SignBias;
		res.len = run_len;
		return res;
	endfunction

	task automatic report(string what, logic [47:0] got, logic [47:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver and input-side prediction
	always @(posedge clk) begin
		txn_t nx;
		logic fire;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (func == bcs_pkg::FuncEval)
					expected_samples.push_back(eval_sample(sample_index));
				else begin
					pt_x[point_index] = point_x ^ bcs_pkg::SignBias;
					pt_y[point_index] = point_y ^ bcs_pkg::SignBias;
				end
			end
			if (!in_valid || in_ready) begin
				fire = pending.size() != 0 && $urandom_range(99) >= send_idle;
				if (fire) begin
					nx = pending.pop_front();
					func <= nx.fn;
					point_index <= nx.slot;
					point_x <= nx.px;
					point_y <= nx.py;
					sample_index <= nx.si;
				end
				in_valid <= fire;
			end
			out_ready <= !hold_off && $urandom_range(99) >= recv_idle;
		end
	end

	// monitor
	always @(posedge clk) begin
		sample_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				$display("unexpected transaction at %0t", $realtime);
				errors++;
			end else begin
				w = expected_samples.pop_front();
				if (curve_x !== w.cx) report("curve_x", 48'(curve_x), 48'(w.cx));
				if (curve_y !== w.cy) report("curve_y", 48'(curve_y), 48'(w.cy));
				if (path_length !== w.len) report("path_length", path_length, w.len);
			end
		end
	end

	task automatic reg_write(logic idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(4 * idx);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == bcs_pkg::RegSegCount) seg_reg = val[10:0];
		else pts_reg = val[4:0];
	endtask

	task automatic add_item(logic fn, logic [3:0] slot, logic [31:0] x, logic [31:0] y,
			logic [10:0] si);
		txn_t it;
		it.fn = fn;
		it.slot = slot;
		it.px = x;
		it.py = y;
		it.si = si;
		pending.push_back(it);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'(int'($urandom_range(200000)) - 100000);
			default: return $urandom;
		endcase
	endfunction

	task automatic drain();
		while (pending.size() != 0 || in_valid || expected_samples.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	task automatic fill_phase(int n);
		int cnt, eff, stride, i;
		cnt = 0;
		eff = (seg_reg == 0) ? 1 :
			(seg_reg > bcs_pkg::MaxSegments) ? bcs_pkg::MaxSegments : seg_reg;
		while (cnt < n) begin
			case ($urandom_range(9))
				0, 1: begin
					add_item(bcs_pkg::FuncWrite, 4'($urandom), rand_coord(), rand_coord(),
						11'($urandom));
					cnt++;
				end
				2: begin
					add_item(bcs_pkg::FuncEval, 4'($urandom), $urandom, $urandom, 11'($urandom));
					cnt++;
				end
				default: begin
					stride = eff / $urandom_range(4, 12);
					if (stride < 1) stride = 1;
					i = 0;
					while (1) begin
						add_item(bcs_pkg::FuncEval, 4'($urandom), $urandom, $urandom, 11'(i));
						cnt++;
						if (i == eff) break;
						if ($urandom_range(15) == 0) begin
							add_item(bcs_pkg::FuncWrite, 4'($urandom), rand_coord(),
								rand_coord(), '0);
							cnt++;
						end
						i = (i + stride > eff) ? eff : i + stride;
					end
				end
			endcase
		end
	endtask

	initial begin
		int segs[8] = '{1, 0, 2047, 1024, 7, 13, 32, 5};
		int ptss[8] = '{2, 1, 31, 16, 3, 5, 0, 8};
		last_x = bcs_pkg::SignBias;
		last_y = bcs_pkg::SignBias;
		run_len = '0;
		seg_reg = bcs_pkg::SegReset;
		pts_reg = bcs_pkg::PtsReset;
		for (int k = 0; k < bcs_pkg::MaxPoints; k++) begin
			pt_x[k] = bcs_pkg::SignBias;
			pt_y[k] = bcs_pkg::SignBias;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fill every slot with extremes, then sweep at reset settings
		for (int k = 0; k < bcs_pkg::MaxPoints; k++)
			add_item(bcs_pkg::FuncWrite, 4'(k), (k % 2) ? 32'h7fff_ffff : 32'h8000_0000,
				(k % 3) ? 32'h8000_0000 : 32'h7fff_ffff, 11'(k));
		add_item(bcs_pkg::FuncEval, '0, '0, '0, 11'd0);
		add_item(bcs_pkg::FuncEval, '0, '0, '0, 11'd50);
		add_item(bcs_pkg::FuncEval, '0, '0, '0, 11'd100);
		add_item(bcs_pkg::FuncEval, '0, '0, '0, 11'd2047);
		add_item(bcs_pkg::FuncWrite, 4'd1, 32'd0, 32'hffff_ffff, '0);
		add_item(bcs_pkg::FuncEval, '1, '1, '1, 11'd1);
		drain();

		for (int p = 0; p < 8; p++) begin
			phase = p;
			send_idle = (p < 3) ? 14 : (p < 6) ? 76 : 0;
			recv_idle = (p < 3) ? 76 : (p < 6) ? 14 : 0;
			reg_write(bcs_pkg::RegSegCount, 32'(segs[p]));
			reg_write(bcs_pkg::RegPointCount, 32'(ptss[p]));
			fill_phase((segs[p] == 1024 || segs[p] == 2047) ? 50 : 110);
			drain();
		end

		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

	// long receiver hold-off so the input side backs up
	initial begin
		wait (phase == 4);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (3000) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
